[rtl/rits_pkg.sv]
// ----------------------------------------------------------------------------
// rits_pkg
// Types, character codes and helper functions for the radix integer text
// parser.
// ----------------------------------------------------------------------------
package rits_pkg;

	localparam int unsigned MAG_W = 64;
	localparam int unsigned WIDE_W = MAG_W + 4;
	localparam logic [MAG_W-1:0] MAG_LIMIT = {1'b1, {(MAG_W-1){1'b0}}};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_Z_UP  = 8'h5A;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_Z_LO  = 8'h7A;
	localparam logic [7:0] CH_K     = 8'h6B;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_T     = 8'h74;

	localparam logic [5:0] DIGIT_NONE = 6'd36;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2
	} radix_t;

	typedef enum logic [1:0] {
		PH_SKIP   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		SCALE_NONE = 3'd0,
		SCALE_K    = 3'd1,
		SCALE_M    = 3'd2,
		SCALE_G    = 3'd3,
		SCALE_T    = 3'd4
	} scale_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
		scale_t           scale;
	} lane_res_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [5:0] digit_value(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if ((c >= CH_0) && (c <= CH_9)) begin
			t = c - CH_0;
		end else if ((c >= CH_A_LO) && (c <= CH_Z_LO)) begin
			t = c - CH_A_LO + 8'd10;
		end else if ((c >= CH_A_UP) && (c <= CH_Z_UP)) begin
			t = c - CH_A_UP + 8'd10;
		end else begin
			t = {2'b00, DIGIT_NONE};
		end
		return t[5:0];
	endfunction

	function automatic scale_t suffix_code(input logic [7:0] c);
		logic [7:0] lc;
		scale_t     s;
		lc = c | 8'h20;
		case (lc)
			CH_K:    s = SCALE_K;
			CH_M:    s = SCALE_M;
			CH_G:    s = SCALE_G;
			CH_T:    s = SCALE_T;
			default: s = SCALE_NONE;
		endcase
		return s;
	endfunction

	function automatic logic [MAG_W-1:0] lane_value(input lane_res_t r);
		logic [MAG_W-1:0] v;
		logic             sat;
		sat = (r.mag >= MAG_LIMIT);
		if (r.neg) begin
			v = sat ? MAG_LIMIT : ({MAG_W{1'b0}} - r.mag);
		end else begin
			v = sat ? (MAG_LIMIT - {{(MAG_W-1){1'b0}}, 1'b1}) : r.mag;
		end
		case (r.scale)
			SCALE_K: v = v << 10;
			SCALE_M: v = v << 20;
			SCALE_G: v = v << 30;
			SCALE_T: v = v << 40;
			default: v = v;
		endcase
		return v;
	endfunction

endpackage

[rtl/rits_lane.sv]
// ----------------------------------------------------------------------------
// rits_lane
// One parse lane: whitespace skip, sign, saturating digit accumulation and
// scale suffix for a fixed radix. Presents its post-update state.
// ----------------------------------------------------------------------------
module rits_lane
	import rits_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  radix_t     radix,
	input  logic       feed,
	input  logic       clear,
	input  logic [7:0] ch,
	output lane_res_t  nxt
);

	phase_t           phase_q, phase_n;
	logic             neg_q, neg_n;
	logic [MAG_W-1:0] mag_q, mag_n;
	scale_t           scale_q, scale_n;

	logic [5:0]        dig;
	logic [5:0]        base;
	logic              is_digit;
	logic [WIDE_W-1:0] wide;
	logic [WIDE_W-1:0] mag_w;

	always_comb begin
		dig   = digit_value(ch);
		mag_w = {4'b0000, mag_q};
		unique case (radix)
			RADIX_HEX: begin
				base = 6'd16;
				wide = (mag_w << 4) + {{(WIDE_W-6){1'b0}}, dig};
			end
			RADIX_BIN: begin
				base = 6'd2;
				wide = (mag_w << 1) + {{(WIDE_W-6){1'b0}}, dig};
			end
			default: begin
				base = 6'd10;
				wide = (mag_w << 3) + (mag_w << 1) + {{(WIDE_W-6){1'b0}}, dig};
			end
		endcase
		is_digit = (ch != CH_NUL) && (dig < base);
	end

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		mag_n   = mag_q;
		scale_n = scale_q;
		if (feed && (phase_q != PH_DONE)) begin
			if (ch == CH_NUL) begin
				phase_n = PH_DONE;
			end else if ((phase_q == PH_SKIP) && is_space(ch)) begin
				phase_n = PH_SKIP;
			end else if ((phase_q == PH_SKIP) && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
				neg_n   = (ch == CH_MINUS);
				phase_n = PH_SIGN;
			end else if (is_digit) begin
				mag_n   = (wide > {4'b0000, MAG_LIMIT}) ? MAG_LIMIT : wide[MAG_W-1:0];
				phase_n = PH_DIGITS;
			end else begin
				if (phase_q == PH_DIGITS) begin
					scale_n = suffix_code(ch);
				end
				phase_n = PH_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			scale_q <= SCALE_NONE;
		end else if (clear) begin
			phase_q <= PH_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			scale_q <= SCALE_NONE;
		end else begin
			phase_q <= phase_n;
			neg_q   <= neg_n;
			mag_q   <= mag_n;
			scale_q <= scale_n;
		end
	end

	assign nxt = '{neg: neg_n, mag: mag_n, scale: scale_n};

endmodule

[rtl/rits_out.sv]
// ----------------------------------------------------------------------------
// rits_out
// Result stage: sign, saturation and suffix shift of the selected lane into
// the output register, with the output handshake and pipeline advance.
// ----------------------------------------------------------------------------
module rits_out
	import rits_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  lane_res_t        res,
	output logic             advance,
	output logic [MAG_W-1:0] value_bits,
	output logic             value_valid,
	input  logic             value_ready
);

	logic             valid_q;
	logic [MAG_W-1:0] value_q;

	assign advance = !valid_q || value_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			value_q <= lane_value(res);
		end
	end

	assign value_valid = valid_q;
	assign value_bits  = value_q;

endmodule

[rtl/radix_integer_text_parser_unit.sv]
// ----------------------------------------------------------------------------
// radix_integer_text_parser_unit
// Pipeline: the final character passes the input register, the lane update
// into the lane result register and the output register, which drives valid.
// Throughput: one character per cycle unless value_ready stalls the output.
// Reset: arst_n clears radix, lanes and all valid flags; ready after release.
// ----------------------------------------------------------------------------
module radix_integer_text_parser_unit
	import rits_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       text_char,
	input  logic             is_final,
	input  logic             text_valid,
	output logic             text_ready,
	output logic [MAG_W-1:0] value_bits,
	output logic             value_valid,
	input  logic             value_ready
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       final_s1;

	logic       valid_s2;
	lane_res_t  res_s2;

	radix_t     radix_q, radix_n;
	logic       adv;
	logic       step;
	logic       marker;
	logic       feed;
	logic       clear;
	lane_res_t  lane_nxt [3];
	lane_res_t  sel;

	assign text_ready = !valid_s1 || adv;
	assign step       = valid_s1 && adv;
	assign marker     = (char_s1 == CH_X_UP) || (char_s1 == CH_X_LO) || (char_s1 == CH_HASH);
	assign feed       = step && !marker;
	assign clear      = step && final_s1;

	always_comb begin
		radix_n = radix_q;
		if ((char_s1 == CH_X_UP) || (char_s1 == CH_X_LO)) begin
			radix_n = RADIX_HEX;
		end else if (char_s1 == CH_HASH) begin
			radix_n = RADIX_BIN;
		end
		unique case (radix_n)
			RADIX_HEX: sel = lane_nxt[1];
			RADIX_BIN: sel = lane_nxt[2];
			default:   sel = lane_nxt[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			radix_q  <= RADIX_DEC;
		end else begin
			if (text_ready) begin
				valid_s1 <= text_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1 && final_s1;
			end
			if (step) begin
				radix_q <= final_s1 ? RADIX_DEC : radix_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			char_s1  <= text_char;
			final_s1 <= is_final;
		end
		if (clear) begin
			res_s2 <= sel;
		end
	end

	rits_lane u_lane_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.radix  (RADIX_DEC),
		.feed   (feed),
		.clear  (clear),
		.ch     (char_s1),
		.nxt    (lane_nxt[0])
	);

	rits_lane u_lane_hex (
		.clk    (clk),
		.arst_n (arst_n),
		.radix  (RADIX_HEX),
		.feed   (feed),
		.clear  (clear),
		.ch     (char_s1),
		.nxt    (lane_nxt[1])
	);

	rits_lane u_lane_bin (
		.clk    (clk),
		.arst_n (arst_n),
		.radix  (RADIX_BIN),
		.feed   (feed),
		.clear  (clear),
		.ch     (char_s1),
		.nxt    (lane_nxt[2])
	);

	rits_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (valid_s2),
		.res         (res_s2),
		.advance     (adv),
		.value_bits  (value_bits),
		.value_valid (value_valid),
		.value_ready (value_ready)
	);

endmodule

[rtl/rits_checker.sv]
// ----------------------------------------------------------------------------
// rits_checker
// Port-level checks for the radix integer text parser, bound to the top level.
// ----------------------------------------------------------------------------
module rits_checker
	import rits_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             is_final,
	input logic             text_valid,
	input logic             text_ready,
	input logic [MAG_W-1:0] value_bits,
	input logic             value_valid,
	input logic             value_ready
);

	logic [2:0] pending_q;
	logic       fin_in;
	logic       res_out;

	assign fin_in  = text_valid && text_ready && is_final;
	assign res_out = value_valid && value_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + {2'b00, fin_in} - {2'b00, res_out};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_ready |=> value_valid && $stable(value_bits))
		else $error("result dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid |-> pending_q != 3'd0)
		else $error("result without a final character transaction");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more results in flight than pipeline stages");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		value_ready |-> text_ready)
		else $error("input stalled while output drains");

endmodule

bind radix_integer_text_parser_unit rits_checker u_rits_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.is_final    (is_final),
	.text_valid  (text_valid),
	.text_ready  (text_ready),
	.value_bits  (value_bits),
	.value_valid (value_valid),
	.value_ready (value_ready)
);
